FILE: rtl/core/mtp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor melody tone player package
// Shared sizes, codes, the controller state type and the quarter-wave sine
// table used by the tone player.
// ----------------------------------------------------------------------------
package mtp_pkg;

    // Note store
    localparam int NOTE_DEPTH = 256;
    localparam int NOTE_AW    = $clog2(NOTE_DEPTH);
    localparam int STEP_W     = $clog2(NOTE_DEPTH + 2);

    typedef logic [NOTE_AW-1:0] t_note_addr;
    typedef logic [STEP_W-1:0]  t_step;

    // Sine table
    localparam int SINE_TABLE_BITS = 10;
    localparam int QTR             = 1 << (SINE_TABLE_BITS - 2);

    // Output saturation range
    localparam int    VOLT_BITS = 16;
    localparam longint VOLT_MAX = (longint'(1) <<< (VOLT_BITS - 1)) - 1;
    localparam longint VOLT_MIN = -VOLT_MAX - 1;

    // Item opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MELODY_LENGTH    = 2'd0,
        CFG_MAGNITUDE        = 2'd1,
        CFG_HZ_TO_PHASE_STEP = 2'd2
    } t_cfg_index;

    localparam logic [23:0] HZ_STEP_RESET  = 24'd214748;
    localparam logic [15:0] MIN_TONE_HZ    = 16'd10;
    localparam logic [15:0] MAX_SILENT_MAG = 16'd25;   // 0.1 V in 1/256 V

    localparam logic signed [15:0] SQRT3_HALF_Q15 = 16'sd28378;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NOTE,
        ST_TONE,
        ST_SCALE,
        ST_MIX,
        ST_SUM,
        ST_OUT
    } t_state;

    // Taylor coefficients of sin(pi/2 * x), Q30
    localparam longint Q30 = longint'(1) <<< 30;
    localparam longint K1  = 64'sd1686629713;
    localparam longint K3  = 64'sd693598668;
    localparam longint K5  = 64'sd85569306;
    localparam longint K7  = 64'sd5026995;
    localparam longint K9  = 64'sd172272;

    typedef logic [15:0] t_qsin_tab [0:QTR];

    // Q15 sin(pi/2 * k / QTR), evaluated at elaboration only
    function automatic logic [15:0] quarter_sin(input int k);
        longint x;
        longint x2;
        longint p;
        longint s;
        x  = longint'(k) <<< (30 - (SINE_TABLE_BITS - 2));
        x2 = x * x / Q30;
        p  = K9;
        p  = -K7 + p * x2 / Q30;
        p  = K5 + p * x2 / Q30;
        p  = -K3 + p * x2 / Q30;
        p  = K1 + p * x2 / Q30;
        s  = p * x / Q30;
        if (s < 0) begin
            s = 0;
        end
        if (s > Q30) begin
            s = Q30;
        end
        return 16'((s * 32767 + (Q30 >>> 1)) >>> 30);
    endfunction

    function automatic t_qsin_tab build_qsin_tab();
        t_qsin_tab t;
        for (int k = 0; k <= QTR; k++) begin
            t[k] = quarter_sin(k);
        end
        return t;
    endfunction

    localparam t_qsin_tab QSIN_TAB = build_qsin_tab();

endpackage

FILE: rtl/core/mtp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone player input channel
// Valid/ready channel carrying load and tick items.
// ----------------------------------------------------------------------------
interface mtp_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [7:0]  note_index;
    logic [15:0] note_freq_hz;
    logic [15:0] note_duration_ms;
    logic [31:0] now_ms;

    modport source (
        output valid, opcode, note_index, note_freq_hz, note_duration_ms, now_ms,
        input  ready
    );
    modport sink (
        input  valid, opcode, note_index, note_freq_hz, note_duration_ms, now_ms,
        output ready
    );
endinterface

FILE: rtl/core/mtp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone player result channel
// Valid/ready channel carrying three phase voltages and the play status.
// ----------------------------------------------------------------------------
interface mtp_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] volt_a;
    logic signed [15:0] volt_b;
    logic signed [15:0] volt_c;
    logic               play_status;

    modport source (
        output valid, volt_a, volt_b, volt_c, play_status,
        input  ready
    );
    modport sink (
        input  valid, volt_a, volt_b, volt_c, play_status,
        output ready
    );
endinterface

FILE: rtl/core/mtp_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone player configuration channel
// Valid/ready register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mtp_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [23:0] wr_data;

    modport source (
        output valid, reg_index, wr_data,
        input  ready
    );
    modport sink (
        input  valid, reg_index, wr_data,
        output ready
    );
endinterface

FILE: rtl/core/mtp_note_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Note store
// One write port, one read port, registered read data. Each word holds
// {frequency_hz, duration_ms}.
// ----------------------------------------------------------------------------
module mtp_note_ram (
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  mtp_pkg::t_note_addr i_wr_addr,
    input  logic [31:0]         i_wr_data,
    input  logic                i_rd_en,
    input  mtp_pkg::t_note_addr i_rd_addr,
    output logic [31:0]         o_rd_data
);

    logic [31:0] r_mem [mtp_pkg::NOTE_DEPTH];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/mtp_sincos_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine/cosine table
// Quarter-wave Q1.15 table mirrored to a full wave; sin and cos of one
// phase index, registered.
// ----------------------------------------------------------------------------
module mtp_sincos_rom (
    input  logic                                       i_clk,
    input  logic                                       i_en,
    input  logic [mtp_pkg::SINE_TABLE_BITS-1:0]        i_idx,
    output logic signed [15:0]                         o_sin,
    output logic signed [15:0]                         o_cos
);

    localparam int SB = mtp_pkg::SINE_TABLE_BITS;
    localparam int KW = SB - 1;

    typedef logic [SB-1:0] t_idx;
    typedef logic [KW-1:0] t_k;

    logic signed [15:0] r_sin;
    logic signed [15:0] r_cos;
    t_idx               cos_idx;

    function automatic logic signed [15:0] wave(input t_idx idx);
        logic [1:0]  quad;
        t_k          rem;
        t_k          k;
        logic [15:0] v;
        quad = idx[SB-1 -: 2];
        rem  = {1'b0, idx[SB-3:0]};
        // odd quadrants run the quarter wave backwards
        k    = quad[0] ? (t_k'(mtp_pkg::QTR) - rem) : rem;
        v    = mtp_pkg::QSIN_TAB[k];
        return quad[1] ? -$signed(v) : $signed(v);
    endfunction

    assign cos_idx = i_idx + t_idx'(mtp_pkg::QTR);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= wave(i_idx);
            r_cos <= wave(cos_idx);
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

FILE: rtl/core/motor_melody_tone_player.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor melody tone player
// Plays a stored melody as a tone on the three motor phases.
// ----------------------------------------------------------------------------
// Load items write one note {frequency, duration} into a 256-entry note store
// and leave the block idle, ready for the next item. Tick items step through a
// silent start step, each note, and a silent completion result (play_status 1)
// before restarting; each tick gives one result, and the next item is taken
// once that result sits in the output register (later while the output is
// stalled). Each tick goes through the single read port of the note store (up
// to two reads per tick: current note, then the next duration), then the
// sin/cos table, the magnitude multiply, the inverse Clarke multiply, the sum
// and the rounding stage. Loads only write while no tick is in flight, so store
// accesses never overlap. Unwritten note entries read back as undefined; the
// store has no clearing pass. Configuration is accepted every cycle and must
// be written only while the block is idle.
// ----------------------------------------------------------------------------
module motor_melody_tone_player (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mtp_in_if.sink        i_item,
    mtp_out_if.source     o_res,
    mtp_cfg_if.sink       i_cfg
);

    localparam int SB = mtp_pkg::SINE_TABLE_BITS;

    // control state
    mtp_pkg::t_state r_state, n_state;
    mtp_pkg::t_step  r_step, n_step;
    logic [31:0]     r_deadline, n_deadline;
    logic [31:0]     r_phase, n_phase;
    logic [8:0]      r_len_cfg;
    logic [15:0]     r_mag;
    logic [23:0]     r_hz;
    logic            r_out_valid;

    // per-tick payload
    logic [31:0]        r_now;
    logic [31:0]        r_inc, n_inc;
    logic               r_silent, n_silent;
    logic               r_status, n_status;
    logic               r_dur_pend, n_dur_pend;
    logic signed [32:0] r_p;
    logic signed [32:0] r_q;
    logic signed [48:0] r_qk;
    logic signed [49:0] r_b_sum;
    logic signed [49:0] r_c_sum;
    logic signed [15:0] r_volt_a;
    logic signed [15:0] r_volt_b;
    logic signed [15:0] r_volt_c;
    logic               r_play_status;

    // handshakes
    logic item_xfer;
    logic out_free;

    // store and table ports
    logic                ram_wr_en;
    mtp_pkg::t_note_addr ram_wr_addr;
    logic                ram_rd_en;
    mtp_pkg::t_note_addr ram_rd_addr;
    logic [31:0]         ram_rd_data;
    logic                rom_en;
    logic signed [15:0]  rom_sin;
    logic signed [15:0]  rom_cos;

    // datapath helpers
    mtp_pkg::t_step     len;
    mtp_pkg::t_step     step_inc;
    logic [15:0]        rd_freq;
    logic [15:0]        rd_dur;
    logic [39:0]        prod;
    logic               adv_more;
    logic signed [49:0] p14;
    logic signed [49:0] qk50;
    logic signed [32:0] a_adj;
    logic signed [32:0] a_rnd;
    logic signed [49:0] b_adj;
    logic signed [49:0] b_rnd;
    logic signed [49:0] c_adj;
    logic signed [49:0] c_rnd;

    function automatic logic [15:0] sat_volt(input logic signed [49:0] v);
        logic signed [49:0] r;
        r = v;
        if (v > 50'(mtp_pkg::VOLT_MAX)) begin
            r = 50'(mtp_pkg::VOLT_MAX);
        end else if (v < 50'(mtp_pkg::VOLT_MIN)) begin
            r = 50'(mtp_pkg::VOLT_MIN);
        end
        return r[15:0];
    endfunction

    assign item_xfer = i_item.valid && i_item.ready;
    assign out_free  = !r_out_valid || o_res.ready;

    // ------------------------------------------------------------------
    // Submodules
    // ------------------------------------------------------------------
    mtp_note_ram u_note_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data ({i_item.note_freq_hz, i_item.note_duration_ms}),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    mtp_sincos_rom u_sincos_rom (
        .i_clk (i_clk),
        .i_en  (rom_en),
        .i_idx (n_phase[31 -: SB]),
        .o_sin (rom_sin),
        .o_cos (rom_cos)
    );

    // ------------------------------------------------------------------
    // Controller: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mtp_pkg::ST_IDLE: begin
                if (item_xfer && (i_item.opcode == mtp_pkg::OP_TICK)) begin
                    n_state = mtp_pkg::ST_NOTE;
                end
            end
            mtp_pkg::ST_NOTE:  n_state = mtp_pkg::ST_TONE;
            mtp_pkg::ST_TONE:  n_state = mtp_pkg::ST_SCALE;
            mtp_pkg::ST_SCALE: n_state = mtp_pkg::ST_MIX;
            mtp_pkg::ST_MIX:   n_state = mtp_pkg::ST_SUM;
            mtp_pkg::ST_SUM:   n_state = mtp_pkg::ST_OUT;
            mtp_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = mtp_pkg::ST_IDLE;
                end
            end
            default: n_state = mtp_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Controller: outputs
    // ------------------------------------------------------------------
    always_comb begin
        i_item.ready = 1'b0;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = mtp_pkg::t_note_addr'(i_item.note_index);
        ram_rd_en    = 1'b0;
        ram_rd_addr  = '0;
        rom_en       = 1'b0;
        unique case (r_state)
            mtp_pkg::ST_IDLE: begin
                i_item.ready = 1'b1;
                ram_wr_en    = item_xfer && (i_item.opcode == mtp_pkg::OP_LOAD) &&
                               (32'(i_item.note_index) < 32'(mtp_pkg::NOTE_DEPTH));
                ram_rd_en    = item_xfer && (i_item.opcode == mtp_pkg::OP_TICK);
                // start step reads entry 0 for its duration
                ram_rd_addr  = (r_step == '0) ? '0 :
                               mtp_pkg::t_note_addr'(r_step - mtp_pkg::t_step'(1));
            end
            mtp_pkg::ST_NOTE: begin
                // next note's duration lives at the old step
                ram_rd_en   = adv_more;
                ram_rd_addr = mtp_pkg::t_note_addr'(r_step);
            end
            mtp_pkg::ST_TONE: begin
                rom_en = 1'b1;
            end
            mtp_pkg::ST_SCALE,
            mtp_pkg::ST_MIX,
            mtp_pkg::ST_SUM,
            mtp_pkg::ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Step sequencing and phase update
    // ------------------------------------------------------------------
    assign rd_freq  = ram_rd_data[31:16];
    assign rd_dur   = ram_rd_data[15:0];
    assign prod     = 40'(rd_freq) * 40'(r_hz);
    assign step_inc = r_step + mtp_pkg::t_step'(1);
    assign len      = (32'(r_len_cfg) > 32'(mtp_pkg::NOTE_DEPTH)) ?
                      mtp_pkg::t_step'(mtp_pkg::NOTE_DEPTH) : mtp_pkg::t_step'(r_len_cfg);

    always_comb begin
        n_step     = r_step;
        n_deadline = r_deadline;
        n_phase    = r_phase;
        n_inc      = r_inc;
        n_silent   = r_silent;
        n_status   = r_status;
        n_dur_pend = r_dur_pend;
        adv_more   = 1'b0;
        if (r_state == mtp_pkg::ST_NOTE) begin
            n_inc      = prod[31:0];
            n_silent   = 1'b1;
            n_status   = 1'b0;
            n_dur_pend = 1'b0;
            if (r_step == '0) begin
                n_step     = mtp_pkg::t_step'(1);
                n_deadline = r_now + 32'(rd_dur);
            end else if (r_step <= len) begin
                n_silent = (rd_freq < mtp_pkg::MIN_TONE_HZ) ||
                           (r_mag <= mtp_pkg::MAX_SILENT_MAG);
                if (r_now >= r_deadline) begin
                    n_step = step_inc;
                    // past the last note no duration is read
                    if (step_inc <= len) begin
                        adv_more   = 1'b1;
                        n_dur_pend = 1'b1;
                    end
                end
            end else begin
                n_step   = '0;
                n_status = 1'b1;
            end
        end
        if (r_state == mtp_pkg::ST_TONE) begin
            if (r_dur_pend) begin
                n_deadline = r_now + 32'(rd_dur);
            end
            if (!r_silent) begin
                n_phase = r_phase + r_inc;
            end
        end
    end

    // ------------------------------------------------------------------
    // Inverse Clarke and rounding helpers (round half away from zero)
    // ------------------------------------------------------------------
    always_comb begin
        p14   = 50'(r_p) <<< 14;
        qk50  = 50'(r_qk);
        a_adj = r_p + 33'(16384) - 33'(r_p[32]);
        a_rnd = a_adj >>> 15;
        b_adj = r_b_sum + 50'(536870912) - 50'(r_b_sum[49]);
        b_rnd = b_adj >>> 30;
        c_adj = r_c_sum + 50'(536870912) - 50'(r_c_sum[49]);
        c_rnd = c_adj >>> 30;
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mtp_pkg::ST_IDLE;
            r_step      <= '0;
            r_deadline  <= '0;
            r_phase     <= '0;
            r_len_cfg   <= '0;
            r_mag       <= '0;
            r_hz        <= mtp_pkg::HZ_STEP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_deadline <= n_deadline;
            r_phase    <= n_phase;
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.reg_index)
                    mtp_pkg::CFG_MELODY_LENGTH:    r_len_cfg <= i_cfg.wr_data[8:0];
                    mtp_pkg::CFG_MAGNITUDE:        r_mag     <= i_cfg.wr_data[15:0];
                    mtp_pkg::CFG_HZ_TO_PHASE_STEP: r_hz      <= i_cfg.wr_data;
                    default: begin
                    end
                endcase
            end
            if ((r_state == mtp_pkg::ST_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign i_cfg.ready = 1'b1;

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_inc      <= n_inc;
        r_silent   <= n_silent;
        r_status   <= n_status;
        r_dur_pend <= n_dur_pend;
        if (item_xfer) begin
            r_now <= i_item.now_ms;
        end
        if (r_state == mtp_pkg::ST_SCALE) begin
            r_p <= $signed({1'b0, r_mag}) * rom_cos;
            r_q <= $signed({1'b0, r_mag}) * rom_sin;
        end
        if (r_state == mtp_pkg::ST_MIX) begin
            r_qk <= r_q * mtp_pkg::SQRT3_HALF_Q15;
        end
        if (r_state == mtp_pkg::ST_SUM) begin
            r_b_sum <= qk50 - p14;
            r_c_sum <= (50'sd0 - p14) - qk50;
        end
        if ((r_state == mtp_pkg::ST_OUT) && out_free) begin
            r_volt_a      <= r_silent ? '0 : $signed(sat_volt(50'(a_rnd)));
            r_volt_b      <= r_silent ? '0 : $signed(sat_volt(b_rnd));
            r_volt_c      <= r_silent ? '0 : $signed(sat_volt(c_rnd));
            r_play_status <= r_status;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.volt_a      = r_volt_a;
    assign o_res.volt_b      = r_volt_b;
    assign o_res.volt_c      = r_volt_c;
    assign o_res.play_status = r_play_status;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef ASSERT_OFF
    a_tick_starts_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (item_xfer && (i_item.opcode == mtp_pkg::OP_TICK)) |=> (r_state == mtp_pkg::ST_NOTE))
        else $error("tick transfer did not start the note read");

    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (item_xfer && (i_item.opcode == mtp_pkg::OP_LOAD)) |=> (r_state == mtp_pkg::ST_IDLE))
        else $error("load transfer left the idle state");

    a_silent_keeps_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == mtp_pkg::ST_TONE) && r_silent) |=> $stable(r_phase))
        else $error("phase advanced on a silent tick");

    a_done_is_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.play_status) |->
        ((o_res.volt_a == '0) && (o_res.volt_b == '0) && (o_res.volt_c == '0)))
        else $error("completion result carries a nonzero voltage");
`endif

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor melody tone player testbench
// Drives note loads, control ticks and register writes over the valid/ready
// channels, predicts every result with an in-bench model of the note
// sequencer and the sine/cosine tone path, and checks each result in order.
// ----------------------------------------------------------------------------
module tb;
    import mtp_pkg::*;

    typedef struct packed {
        logic signed [15:0] volt_a;
        logic signed [15:0] volt_b;
        logic signed [15:0] volt_c;
        logic               play_status;
    } t_volts;

    typedef struct {
        logic        opcode;
        logic [7:0]  note_index;
        logic [15:0] freq_hz;
        logic [15:0] dur_ms;
        logic [31:0] now_ms;
    } t_item;

    typedef enum logic [1:0] {ROW_LOAD, ROW_TICK, ROW_CFG} t_row_kind;

    // sel: note index or register index; val: frequency, time or write data
    typedef struct {
        t_row_kind   kind;
        logic [7:0]  sel;
        logic [31:0] val;
        logic [15:0] dur;
        logic        fixed;
        t_volts      want;
    } t_plan_row;

    localparam logic [1:0] CFG_NO_REG = 2'd3;

    localparam longint ONE_Q30  = longint'(1) <<< 30;
    localparam longint POLY_C1  = 64'sd1686629713;
    localparam longint POLY_C3  = 64'sd693598668;
    localparam longint POLY_C5  = 64'sd85569306;
    localparam longint POLY_C7  = 64'sd5026995;
    localparam longint POLY_C9  = 64'sd172272;
    localparam longint SIN60_Q15 = 64'sd28378;
    localparam int     TONE_MIN_HZ    = 10;
    localparam int     MAG_SILENT_MAX = 25;

    localparam t_volts QUIET = '0;
    localparam t_volts DONE  = '{16'sd0, 16'sd0, 16'sd0, 1'b1};

    localparam int N_PLAN = 26;

    // Directed part: start step, empty melody, rests, extremes, silence edges
    t_plan_row directed_plan [N_PLAN] = '{
        '{ROW_LOAD, 8'd0,   32'd440,        16'd2,     1'b0, QUIET},
        '{ROW_TICK, 8'd0,   32'd0,          16'd0,     1'b1, QUIET},
        '{ROW_TICK, 8'd0,   32'd0,          16'd0,     1'b1, DONE},
        '{ROW_CFG,  8'(CFG_MELODY_LENGTH),    32'd3,      16'd0, 1'b0, QUIET},
        '{ROW_CFG,  8'(CFG_MAGNITUDE),        32'd65535,  16'd0, 1'b0, QUIET},
        '{ROW_LOAD, 8'd1,   32'd9,          16'd0,     1'b0, QUIET},
        '{ROW_LOAD, 8'd2,   32'd65535,      16'd65535, 1'b0, QUIET},
        '{ROW_TICK, 8'd0,   32'd100,        16'd0,     1'b1, QUIET},
        '{ROW_TICK, 8'd0,   32'd100,        16'd0,     1'b0, QUIET},
        '{ROW_TICK, 8'd0,   32'd102,        16'd0,     1'b0, QUIET},
        '{ROW_TICK, 8'd0,   32'hFFFF_FFFF,  16'd0,     1'b1, QUIET},
        '{ROW_TICK, 8'd0,   32'd0,          16'd0,     1'b0, QUIET},
        '{ROW_TICK, 8'd0,   32'd65534,      16'd0,     1'b0, QUIET},
        '{ROW_TICK, 8'd0,   32'd65534,      16'd0,     1'b1, DONE},
        '{ROW_CFG,  8'(CFG_MAGNITUDE),        32'd25,     16'd0, 1'b0, QUIET},
        '{ROW_TICK, 8'd0,   32'd7,          16'd0,     1'b1, QUIET},
        '{ROW_TICK, 8'd0,   32'd8,          16'd0,     1'b1, QUIET},
        '{ROW_CFG,  8'(CFG_MAGNITUDE),        32'd26,     16'd0, 1'b0, QUIET},
        '{ROW_CFG,  8'(CFG_HZ_TO_PHASE_STEP), 32'hFFFFFF, 16'd0, 1'b0, QUIET},
        '{ROW_TICK, 8'd0,   32'd8,          16'd0,     1'b0, QUIET},
        '{ROW_CFG,  8'(CFG_HZ_TO_PHASE_STEP), 32'd0,      16'd0, 1'b0, QUIET},
        '{ROW_LOAD, 8'd255, 32'd0,          16'd0,     1'b0, QUIET},
        '{ROW_LOAD, 8'd0,   32'd10,         16'd1,     1'b0, QUIET},
        '{ROW_TICK, 8'd0,   32'd9,          16'd0,     1'b0, QUIET},
        '{ROW_CFG,  8'(CFG_NO_REG),           32'hFFFFFF, 16'd0, 1'b0, QUIET},
        '{ROW_TICK, 8'd0,   32'd9,          16'd0,     1'b1, QUIET}
    };

    logic i_clk;
    logic i_rst_n;

    mtp_in_if  item_ch ();
    mtp_out_if res_ch ();
    mtp_cfg_if cfg_ch ();

    motor_melody_tone_player u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // Sequencer model state and register copies
    logic [15:0] note_freq [NOTE_DEPTH];
    logic [15:0] note_dur  [NOTE_DEPTH];
    int          play_step;
    logic [31:0] deadline_ms;
    logic [31:0] phase_acc;
    logic [8:0]  cfg_len;
    logic [15:0] cfg_mag;
    logic [23:0] cfg_hz_step;
    longint      wave_q [0:QTR];

    t_volts      volts_due [$];
    int          finished_melodies;
    int          items_sent;
    int          mismatches;
    bit          gaps_on;
    int          rx_hold;
    logic [31:0] wall_ms;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tone path model
    // ------------------------------------------------------------------------
    function automatic longint quarter_wave(input int k);
        longint x;
        longint x2;
        longint acc;
        longint s;
        x   = longint'(k) <<< (30 - (SINE_TABLE_BITS - 2));
        x2  = x * x / ONE_Q30;
        acc = POLY_C9;
        acc = -POLY_C7 + acc * x2 / ONE_Q30;
        acc = POLY_C5 + acc * x2 / ONE_Q30;
        acc = -POLY_C3 + acc * x2 / ONE_Q30;
        acc = POLY_C1 + acc * x2 / ONE_Q30;
        s   = acc * x / ONE_Q30;
        if (s < 0) begin
            s = 0;
        end
        if (s > ONE_Q30) begin
            s = ONE_Q30;
        end
        return (s * 32767 + (ONE_Q30 >>> 1)) >>> 30;
    endfunction

    function automatic longint wave_at(input logic [SINE_TABLE_BITS-1:0] idx);
        logic [1:0] quad;
        int         r;
        longint     v;
        quad = idx[SINE_TABLE_BITS-1 -: 2];
        r    = int'(idx[SINE_TABLE_BITS-3:0]);
        v    = quad[0] ? wave_q[QTR - r] : wave_q[r];
        return quad[1] ? -v : v;
    endfunction

    function automatic longint round_away(input longint v, input int sh);
        longint half;
        half = longint'(1) <<< (sh - 1);
        if (v >= 0) begin
            return (v + half) >>> sh;
        end
        return -((-v + half) >>> sh);
    endfunction

    function automatic logic signed [15:0] clamp_volt(input longint v);
        if (v > VOLT_MAX) begin
            v = VOLT_MAX;
        end
        if (v < VOLT_MIN) begin
            v = VOLT_MIN;
        end
        return 16'(v);
    endfunction

    function automatic t_volts tone_volts(input logic [15:0] freq, input logic [15:0] mag);
        t_volts                     r;
        logic [SINE_TABLE_BITS-1:0] idx;
        longint                     p;
        longint                     q;
        r = '0;
        if (freq < TONE_MIN_HZ || mag <= MAG_SILENT_MAX) begin
            return r;
        end
        phase_acc = phase_acc + 32'(freq) * 32'(cfg_hz_step);
        idx = phase_acc[31 -: SINE_TABLE_BITS];
        p = longint'(mag) * wave_at(SINE_TABLE_BITS'(idx + QTR));
        q = longint'(mag) * wave_at(idx);
        r.volt_a = clamp_volt(round_away(p, 15));
        r.volt_b = clamp_volt(round_away(-p * 16384 + q * SIN60_Q15, 30));
        r.volt_c = clamp_volt(round_away(-p * 16384 - q * SIN60_Q15, 30));
        return r;
    endfunction

    // One tick of the note sequencer: silent start, each note, completion
    function automatic t_volts play_tick(input logic [31:0] now);
        t_volts r;
        int     eff_len;
        eff_len = (cfg_len > NOTE_DEPTH) ? NOTE_DEPTH : int'(cfg_len);
        r = QUIET;
        if (play_step == 0) begin
            play_step   = 1;
            deadline_ms = now + note_dur[0];
        end else if (play_step <= eff_len) begin
            r = tone_volts(note_freq[play_step - 1], cfg_mag);
            if (now >= deadline_ms) begin
                play_step++;
                // past the last note the deadline stays as it is
                if (play_step <= eff_len) begin
                    deadline_ms = now + note_dur[play_step - 1];
                end
            end
        end else begin
            play_step     = 0;
            r.play_status = 1'b1;
            finished_melodies++;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------
    function automatic t_item note_item(input logic [7:0] idx, input logic [15:0] freq,
                                       input logic [15:0] dur);
        t_item it;
        it = '{OP_LOAD, idx, freq, dur, 32'($urandom)};
        return it;
    endfunction

    function automatic t_item tick_item(input logic [31:0] now);
        t_item it;
        it = '{OP_TICK, 8'($urandom), 16'($urandom), 16'($urandom), now};
        return it;
    endfunction

    function automatic t_item random_note(input logic [7:0] idx, input int max_dur);
        logic [15:0] freq;
        logic [15:0] dur;
        case ($urandom_range(0, 9))
            0:       freq = 16'($urandom_range(0, TONE_MIN_HZ - 1));
            1:       freq = 16'($urandom_range(0, 65535));
            default: freq = 16'($urandom_range(TONE_MIN_HZ, 4000));
        endcase
        dur = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 65535))
                                            : 16'($urandom_range(0, max_dur));
        return note_item(idx, freq, dur);
    endfunction

    task automatic send_item(input t_item it, input bit fixed, input t_volts want);
        t_volts predicted;
        @(negedge i_clk);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            item_ch.valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        item_ch.valid            = 1'b1;
        item_ch.opcode           = it.opcode;
        item_ch.note_index       = it.note_index;
        item_ch.note_freq_hz     = it.freq_hz;
        item_ch.note_duration_ms = it.dur_ms;
        item_ch.now_ms           = it.now_ms;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        items_sent++;
        if (it.opcode == OP_LOAD) begin
            note_freq[it.note_index] = it.freq_hz;
            note_dur[it.note_index]  = it.dur_ms;
        end else begin
            predicted = play_tick(it.now_ms);
            volts_due.push_back(fixed ? want : predicted);
        end
    endtask

    task automatic send_tick();
        wall_ms = ($urandom_range(0, 24) == 0) ? 32'($urandom)
                                                : wall_ms + $urandom_range(0, 3);
        send_item(tick_item(wall_ms), 1'b0, QUIET);
    endtask

    // Stop offering items and wait until the block has nothing in flight
    task automatic settle();
        @(negedge i_clk);
        item_ch.valid = 1'b0;
        while (volts_due.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
        @(negedge i_clk);
        cfg_ch.valid     = 1'b1;
        cfg_ch.reg_index = idx;
        cfg_ch.wr_data   = data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            CFG_MELODY_LENGTH:    cfg_len     = data[8:0];
            CFG_MAGNITUDE:        cfg_mag     = data[15:0];
            CFG_HZ_TO_PHASE_STEP: cfg_hz_step = data;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    function automatic logic [23:0] pick_mag();
        case ($urandom_range(0, 6))
            0:       return 24'd0;
            1:       return 24'(MAG_SILENT_MAX);
            2:       return 24'(MAG_SILENT_MAX + 1);
            3:       return 24'd65535;
            default: return 24'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [23:0] pick_hz_step();
        case ($urandom_range(0, 5))
            0:       return 24'd0;
            1:       return 24'hFFFFFF;
            2:       return HZ_STEP_RESET;
            default: return 24'($urandom);
        endcase
    endfunction

    // One melody: set registers, load the first notes, tick until it completes or the tick limit is reached
    task automatic run_melody(input logic [8:0] len, input int reload, input int max_dur,
                              input int max_ticks, input bit hold_rx);
        int start;
        int n;
        settle();
        write_reg(CFG_MELODY_LENGTH, 24'(len));
        if ($urandom_range(0, 1) == 0) begin
            write_reg(CFG_MAGNITUDE, pick_mag());
        end
        if ($urandom_range(0, 2) == 0) begin
            write_reg(CFG_HZ_TO_PHASE_STEP, pick_hz_step());
        end
        if ($urandom_range(0, 7) == 0) begin
            write_reg(CFG_NO_REG, 24'($urandom));
        end
        for (int i = 0; i < reload; i++) begin
            send_item(random_note(8'(i), max_dur), 1'b0, QUIET);
        end
        if (hold_rx) begin
            rx_hold = 200;
        end
        start = finished_melodies;
        n = 0;
        while (n < max_ticks && finished_melodies == start) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(random_note(8'($urandom), max_dur), 1'b0, QUIET);
            end
            send_tick();
            n++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                res_ch.ready = 1'b0;
                repeat (rx_hold - 1) @(negedge i_clk);
                rx_hold = 0;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                res_ch.ready = 1'b0;
                repeat ($urandom_range(0, 4)) @(negedge i_clk);
            end else begin
                res_ch.ready = 1'b1;
            end
        end
    end

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40) begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_volts want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (volts_due.size() == 0) begin
                flag_mismatch("result transfer with nothing outstanding");
            end else begin
                want = volts_due.pop_front();
                if (res_ch.volt_a !== want.volt_a) begin
                    flag_mismatch($sformatf("volt_a got %0d want %0d",
                                            res_ch.volt_a, want.volt_a));
                end
                if (res_ch.volt_b !== want.volt_b) begin
                    flag_mismatch($sformatf("volt_b got %0d want %0d",
                                            res_ch.volt_b, want.volt_b));
                end
                if (res_ch.volt_c !== want.volt_c) begin
                    flag_mismatch($sformatf("volt_c got %0d want %0d",
                                            res_ch.volt_c, want.volt_c));
                end
                if (res_ch.play_status !== want.play_status) begin
                    flag_mismatch($sformatf("play_status got %0b want %0b",
                                            res_ch.play_status, want.play_status));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        t_plan_row row;
        int        short_target;
        int        phase;
        int        pick;
        logic [8:0] len;

        item_ch.valid            = 1'b0;
        item_ch.opcode           = OP_LOAD;
        item_ch.note_index       = '0;
        item_ch.note_freq_hz     = '0;
        item_ch.note_duration_ms = '0;
        item_ch.now_ms           = '0;
        cfg_ch.valid             = 1'b0;
        cfg_ch.reg_index         = CFG_MELODY_LENGTH;
        cfg_ch.wr_data           = '0;
        i_rst_n                  = 1'b0;

        for (int k = 0; k <= QTR; k++) begin
            wave_q[k] = quarter_wave(k);
        end
        for (int k = 0; k < NOTE_DEPTH; k++) begin
            note_freq[k] = '0;
            note_dur[k]  = '0;
        end
        play_step         = 0;
        deadline_ms       = '0;
        phase_acc         = '0;
        cfg_len           = '0;
        cfg_mag           = '0;
        cfg_hz_step       = HZ_STEP_RESET;
        finished_melodies = 0;
        items_sent        = 0;
        mismatches        = 0;
        gaps_on           = 1'b1;
        rx_hold           = 0;
        wall_ms           = 32'($urandom);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < N_PLAN; i++) begin
            row = directed_plan[i];
            case (row.kind)
                ROW_CFG: begin
                    settle();
                    write_reg(row.sel[1:0], row.val[23:0]);
                end
                ROW_LOAD: send_item(note_item(row.sel, row.val[15:0], row.dur), 1'b0, QUIET);
                default:  send_item(tick_item(row.val), row.fixed, row.want);
            endcase
        end

        // Full-depth melody with an oversized length; fills every note entry,
        // so later melodies never read an entry that was never loaded.
        run_melody(9'd511, NOTE_DEPTH, 1, 900, 1'b0);

        short_target = items_sent + 400;
        phase = 0;
        while (items_sent < short_target) begin
            if (items_sent > short_target - 80) begin
                gaps_on = 1'b0;
            end
            pick = $urandom_range(0, 11);
            if (pick == 0) begin
                len = 9'd0;
            end else if (pick == 1) begin
                len = 9'(NOTE_DEPTH);
            end else begin
                len = 9'($urandom_range(1, 8));
            end
            if (phase == 3) begin
                // receiver holds off while ticks keep coming
                run_melody(9'd8, 8, 2, 40, 1'b1);
            end else begin
                run_melody(len, (len == 0) ? 1 : ((len > 8) ? 8 : int'(len)), 6, 40, 1'b0);
            end
            phase++;
        end

        settle();
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
